@@ hw/rtl/msps_pkg.sv @@
// Shared types and constants for the minimum-spacing point scatter.
// Used by msps_dist and by the top level; has no dependencies of its own.
package msps_pkg;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 1'b1;

    localparam int SPACING_W = 49;
    localparam int TARGET_W  = 11;

    // Field widths of the transactions.
    localparam int ID_W    = 10;
    localparam int YAW_W   = 16;
    localparam int SCALE_W = 16;
    localparam int MODEL_W = 8;
    localparam int STAT_W  = 2;

    // The attempt limit reaches 2047 * 24 + 64 at most, which needs 16 bits.
    localparam int ATT_W              = 16;
    localparam int ATTEMPTS_PER_POINT = 24;
    localparam int ATTEMPTS_EXTRA     = 64;

    // Operation codes.
    localparam logic OP_BEGIN     = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_BEGIN     = 2'd0;
    localparam logic [STAT_W-1:0] ST_PLACED    = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_CLOSE = 2'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd3;

    // Status of the distance pipeline as seen by the controller.
    typedef struct packed {
        logic hit;   // a stored point lies closer than the spacing
        logic busy;  // comparisons still in flight
    } dist_stat_t;

endpackage

@@ hw/rtl/msps_store.sv @@
// Point store: a single-port-write, single-port-read synchronous memory
// with a registered read. No dependencies.
module msps_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int WIDTH  = 48
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/msps_dist.sv @@
// Three-stage distance check between the candidate and one stored point:
// absolute differences, squares, then sum and compare. Depends on msps_pkg.
module msps_dist #(
    parameter int COORD_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic signed [COORD_BITS-1:0]         cand_x,
    input  logic signed [COORD_BITS-1:0]         cand_z,
    input  logic signed [COORD_BITS-1:0]         pt_x,
    input  logic signed [COORD_BITS-1:0]         pt_z,
    input  logic [msps_pkg::SPACING_W-1:0]       spacing_sq,
    output msps_pkg::dist_stat_t                 stat
);
    import msps_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int CMP_W = (SQ_W + 1 > SPACING_W) ? SQ_W + 1 : SPACING_W;

    logic                         v1_reg, v2_reg, v3_reg;
    logic [COORD_BITS-1:0]        dx_reg, dz_reg;
    logic [SQ_W-1:0]              sqx_reg, sqz_reg;
    logic                         hit_reg;

    logic signed [COORD_BITS:0]   diff_x, diff_z;
    logic signed [COORD_BITS:0]   mag_x, mag_z;
    logic [CMP_W-1:0]             dist_sum;
    logic                         too_close;

    // The difference of two COORD_BITS values fits COORD_BITS+1 bits signed,
    // and its magnitude always fits COORD_BITS bits unsigned.
    always_comb begin
        diff_x = $signed({pt_x[COORD_BITS-1], pt_x}) - $signed({cand_x[COORD_BITS-1], cand_x});
        diff_z = $signed({pt_z[COORD_BITS-1], pt_z}) - $signed({cand_z[COORD_BITS-1], cand_z});
        mag_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
        mag_z  = diff_z[COORD_BITS] ? -diff_z : diff_z;
    end

    // The sum is kept at full width, so no saturation is needed to compare.
    always_comb begin
        dist_sum  = CMP_W'(sqx_reg) + CMP_W'(sqz_reg);
        too_close = dist_sum < CMP_W'(spacing_sq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            hit_reg <= v2_reg && too_close;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= mag_x[COORD_BITS-1:0];
        dz_reg  <= mag_z[COORD_BITS-1:0];
        sqx_reg <= dx_reg * dx_reg;
        sqz_reg <= dz_reg * dz_reg;
    end

    assign stat.hit  = hit_reg;
    assign stat.busy = v1_reg | v2_reg | v3_reg;

endmodule

@@ hw/rtl/min_spacing_point_scatter.sv @@
// Minimum-spacing point scatter top level: controller, counters and registers.
// Depends on msps_pkg, msps_store and msps_dist.
//
// A begin transaction or a candidate that arrives after the batch is finished
// yields its result straight from the evaluate state through the finish
// state. A candidate is compared with every point already placed in the
// batch, one per cycle through the single read port of the point store
// followed by the store's read register and the distance pipeline; when the
// spacing is zero or the store is empty, it is placed without a scan.
// The next transaction is accepted as soon as the result is in the output
// register, even while it waits to be taken. The store is never cleared:
// only entries below the placed count are read, and each was written in the
// current batch, so the block is ready right after reset.
module min_spacing_point_scatter #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [msps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msps_pkg::SPACING_W-1:0]      cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [COORD_BITS-1:0]        s_cand_x,
    input  logic signed [COORD_BITS-1:0]        s_cand_z,
    input  logic [msps_pkg::YAW_W-1:0]          s_cand_yaw,
    input  logic [msps_pkg::SCALE_W-1:0]        s_cand_scale,
    input  logic [msps_pkg::MODEL_W-1:0]        s_cand_model,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [msps_pkg::STAT_W-1:0]         m_status,
    output logic [msps_pkg::ID_W-1:0]           m_instance_id,
    output logic signed [COORD_BITS-1:0]        m_out_x,
    output logic signed [COORD_BITS-1:0]        m_out_z,
    output logic [msps_pkg::YAW_W-1:0]          m_out_yaw,
    output logic [msps_pkg::SCALE_W-1:0]        m_out_scale,
    output logic [msps_pkg::MODEL_W-1:0]        m_out_model,
    output logic                                m_finished
);
    import msps_pkg::*;

    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int TARGET_MAX = (1 << TARGET_W) - 1;
    localparam int TARGET_CAP = (MAX_POINTS > TARGET_MAX) ? TARGET_MAX : MAX_POINTS;
    localparam int PT_W       = 2 * COORD_BITS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [SPACING_W-1:0]         spacing_reg;
    logic [TARGET_W-1:0]          target_reg;
    logic [TARGET_W-1:0]          placed_reg, placed_next;
    logic [ATT_W-1:0]             attempt_reg, attempt_next;
    logic [TARGET_W-1:0]          scan_reg, scan_next;
    logic                         close_reg, close_next;
    logic                         rd_vld_reg;
    logic                         m_valid_reg, m_valid_next;

    // Held transaction and staged result.
    logic                         op_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cz_reg;
    logic [YAW_W-1:0]             yaw_reg;
    logic [SCALE_W-1:0]           scale_reg;
    logic [MODEL_W-1:0]           model_reg;
    logic [STAT_W-1:0]            res_status_reg, res_status_next;
    logic                         res_place_reg, res_place_next;
    logic [ID_W-1:0]              res_id_reg, res_id_next;

    logic [TARGET_W-1:0]          eff_target;
    logic [ATT_W-1:0]             attempt_limit;
    logic                         batch_done;
    logic                         in_fire;
    logic                         place_en;
    logic                         rd_en;
    logic                         out_load;
    logic [PT_W-1:0]              rd_data;
    dist_stat_t                   dstat;

    assign s_ready = (state_reg == S_IDLE);
    assign in_fire = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        eff_target    = (target_reg > TARGET_W'(TARGET_CAP)) ? TARGET_W'(TARGET_CAP)
                                                             : target_reg;
        attempt_limit = ATT_W'(eff_target) * ATT_W'(ATTEMPTS_PER_POINT)
                      + ATT_W'(ATTEMPTS_EXTRA);
        batch_done    = (placed_reg >= eff_target) || (attempt_reg >= attempt_limit);
        rd_en         = (state_reg == S_SCAN) && (scan_reg < placed_reg);
    end

    always_comb begin
        state_next      = state_reg;
        placed_next     = placed_reg;
        attempt_next    = attempt_reg;
        scan_next       = scan_reg;
        close_next      = close_reg;
        res_status_next = res_status_reg;
        res_place_next  = res_place_reg;
        res_id_next     = res_id_reg;
        place_en        = 1'b0;
        out_load        = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                close_next     = 1'b0;
                scan_next      = '0;
                res_place_next = 1'b0;
                res_id_next    = '0;
                if (op_reg == OP_BEGIN) begin
                    placed_next     = '0;
                    attempt_next    = '0;
                    res_status_next = ST_BEGIN;
                    state_next      = S_FINISH;
                end else if (batch_done) begin
                    res_status_next = ST_IGNORED;
                    state_next      = S_FINISH;
                end else begin
                    attempt_next = attempt_reg + 1'b1;
                    if ((spacing_reg == '0) || (placed_reg == '0)) begin
                        place_en        = 1'b1;
                        placed_next     = placed_reg + 1'b1;
                        res_status_next = ST_PLACED;
                        res_place_next  = 1'b1;
                        res_id_next     = placed_reg[ID_W-1:0];
                        state_next      = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    scan_next = scan_reg + 1'b1;
                end
                close_next = close_reg | dstat.hit;
                // Every read has been issued and every comparison has drained.
                if (!rd_en && !rd_vld_reg && !dstat.busy) begin
                    if (close_reg) begin
                        res_status_next = ST_TOO_CLOSE;
                    end else begin
                        place_en        = 1'b1;
                        placed_next     = placed_reg + 1'b1;
                        res_status_next = ST_PLACED;
                        res_place_next  = 1'b1;
                        res_id_next     = placed_reg[ID_W-1:0];
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            spacing_reg <= '0;
            target_reg  <= '0;
            placed_reg  <= '0;
            attempt_reg <= '0;
            scan_reg    <= '0;
            close_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            placed_reg  <= placed_next;
            attempt_reg <= attempt_next;
            scan_reg    <= scan_next;
            close_reg   <= close_next;
            rd_vld_reg  <= rd_en;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SPACING: spacing_reg <= cfg_wdata;
                    REG_TARGET:  target_reg  <= cfg_wdata[TARGET_W-1:0];
                    default:     spacing_reg <= spacing_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg    <= s_operation;
            cx_reg    <= s_cand_x;
            cz_reg    <= s_cand_z;
            yaw_reg   <= s_cand_yaw;
            scale_reg <= s_cand_scale;
            model_reg <= s_cand_model;
        end
        res_status_reg <= res_status_next;
        res_place_reg  <= res_place_next;
        res_id_reg     <= res_id_next;
        if (out_load) begin
            m_status      <= res_status_reg;
            m_instance_id <= res_id_reg;
            m_out_x       <= res_place_reg ? cx_reg : '0;
            m_out_z       <= res_place_reg ? cz_reg : '0;
            m_out_yaw     <= res_place_reg ? yaw_reg : '0;
            m_out_scale   <= res_place_reg ? scale_reg : '0;
            m_out_model   <= res_place_reg ? model_reg : '0;
            m_finished    <= batch_done;
        end
    end

    // Writes go to the entry at the placed count, which no read of the same
    // candidate touches, so no forwarding is needed.
    msps_store #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W),
        .WIDTH  (PT_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (place_en),
        .wr_addr (ADDR_W'(placed_reg)),
        .wr_data ({cx_reg, cz_reg}),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(scan_reg)),
        .rd_data (rd_data)
    );

    msps_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rd_vld_reg),
        .cand_x     (cx_reg),
        .cand_z     (cz_reg),
        .pt_x       (rd_data[PT_W-1:COORD_BITS]),
        .pt_z       (rd_data[COORD_BITS-1:0]),
        .spacing_sq (spacing_reg),
        .stat       (dstat)
    );

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (scan_reg <= placed_reg))
        else $error("scan index ran past the placed count");

    a_hit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        dstat.hit |-> (state_reg == S_SCAN))
        else $error("distance hit arrived outside a scan");

    a_place_step: assert property (@(posedge aclk) disable iff (!aresetn)
        place_en |=> (placed_reg == TARGET_W'($past(placed_reg) + 1'b1)))
        else $error("placed count did not advance on a placement");

    a_place_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(placed_reg) <= MAX_POINTS)
        else $error("placed count exceeds the store depth");

endmodule

@@ sim/tb_min_spacing_point_scatter.sv @@
// Self-checking testbench for min_spacing_point_scatter: directed and random batches,
// predicted results and per-field checks. Depends on msps_pkg and the block's RTL only.
module tb_min_spacing_point_scatter;
    timeunit 1ns;
    timeprecision 1ps;

    import msps_pkg::*;

    localparam int CW           = 24;
    localparam int MAX_PTS      = 1024;
    localparam int CLK_PERIOD   = 8;
    localparam int ITEMS_TOTAL  = 580;
    localparam int LIMIT_CYCLES = 3_000_000;

    typedef struct packed {
        logic               op;
        logic [CW-1:0]      x;
        logic [CW-1:0]      z;
        logic [YAW_W-1:0]   yaw;
        logic [SCALE_W-1:0] scale;
        logic [MODEL_W-1:0] model;
    } scatter_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    id;
        logic [CW-1:0]      x;
        logic [CW-1:0]      z;
        logic [YAW_W-1:0]   yaw;
        logic [SCALE_W-1:0] scale;
        logic [MODEL_W-1:0] model;
        logic               finished;
    } placement_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPACING_W-1:0] cfg_wdata = '0;

    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic               s_operation  = OP_BEGIN;
    logic [CW-1:0]      s_cand_x     = '0;
    logic [CW-1:0]      s_cand_z     = '0;
    logic [YAW_W-1:0]   s_cand_yaw   = '0;
    logic [SCALE_W-1:0] s_cand_scale = '0;
    logic [MODEL_W-1:0] s_cand_model = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic [ID_W-1:0]    m_instance_id;
    logic [CW-1:0]      m_out_x;
    logic [CW-1:0]      m_out_z;
    logic [YAW_W-1:0]   m_out_yaw;
    logic [SCALE_W-1:0] m_out_scale;
    logic [MODEL_W-1:0] m_out_model;
    logic               m_finished;

    min_spacing_point_scatter #(
        .MAX_POINTS (MAX_PTS),
        .COORD_BITS (CW)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_cand_x      (s_cand_x),
        .s_cand_z      (s_cand_z),
        .s_cand_yaw    (s_cand_yaw),
        .s_cand_scale  (s_cand_scale),
        .s_cand_model  (s_cand_model),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_instance_id (m_instance_id),
        .m_out_x       (m_out_x),
        .m_out_z       (m_out_z),
        .m_out_yaw     (m_out_yaw),
        .m_out_scale   (m_out_scale),
        .m_out_model   (m_out_model),
        .m_finished    (m_finished)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Predictor state: the points of the current batch, the counters and the registers.
    logic [CW-1:0]        placed_x [MAX_PTS];
    logic [CW-1:0]        placed_z [MAX_PTS];
    int unsigned          n_placed   = 0;
    int unsigned          n_tried    = 0;
    logic [SPACING_W-1:0] spacing_sq = '0;
    logic [TARGET_W-1:0]  target_reg = '0;

    placement_t placement_q [$];
    placement_t got_r;
    placement_t want_r;
    int         mismatches   = 0;
    int         sent_items   = 0;
    int         burst_left   = 0;
    int         ready_hold   = 0;
    int         cycle_count  = 0;

    function automatic bit batch_closed();
        int unsigned t;
        t = (target_reg > MAX_PTS) ? MAX_PTS : target_reg;
        return (n_placed >= t) || (n_tried >= t * ATTEMPTS_PER_POINT + ATTEMPTS_EXTRA);
    endfunction

    function automatic placement_t place_candidate(scatter_item_t it);
        placement_t r;
        bit         clear;
        longint     dx;
        longint     dz;
        r = '0;
        clear = 1'b1;
        if (it.op == OP_BEGIN) begin
            n_placed = 0;
            n_tried = 0;
            r.status = ST_BEGIN;
            r.finished = batch_closed();
            return r;
        end
        if (batch_closed()) begin
            r.status = ST_IGNORED;
            r.finished = 1'b1;
            return r;
        end
        n_tried++;
        if (spacing_sq != '0) begin
            for (int k = 0; k < n_placed && clear; k++) begin
                dx = longint'($signed(placed_x[k])) - longint'($signed(it.x));
                dz = longint'($signed(placed_z[k])) - longint'($signed(it.z));
                // Coordinates are 24 bits wide, so the sum of squares stays below 2^50.
                if (dx * dx + dz * dz < longint'(spacing_sq))
                    clear = 1'b0;
            end
        end
        if (!clear) begin
            r.status = ST_TOO_CLOSE;
        end else begin
            placed_x[n_placed] = it.x;
            placed_z[n_placed] = it.z;
            r.status = ST_PLACED;
            r.id     = ID_W'(n_placed);
            r.x      = it.x;
            r.z      = it.z;
            r.yaw    = it.yaw;
            r.scale  = it.scale;
            r.model  = it.model;
            n_placed++;
        end
        r.finished = batch_closed();
        return r;
    endfunction

    function automatic scatter_item_t begin_item();
        scatter_item_t it;
        it = '0;
        it.op = OP_BEGIN;
        return it;
    endfunction

    function automatic scatter_item_t candidate(int x, int z);
        scatter_item_t it;
        it.op    = OP_CANDIDATE;
        it.x     = CW'(x);
        it.z     = CW'(z);
        it.yaw   = YAW_W'($urandom);
        it.scale = SCALE_W'($urandom);
        it.model = MODEL_W'($urandom);
        return it;
    endfunction

    // Sender: bursts of random length with random gaps; valid stays up inside a burst.
    task automatic send_item(input scatter_item_t it);
        int         gap;
        placement_t pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_operation  <= it.op;
        s_cand_x     <= it.x;
        s_cand_z     <= it.z;
        s_cand_yaw   <= it.yaw;
        s_cand_scale <= it.scale;
        s_cand_model <= it.model;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = place_candidate(it);
        placement_q.insert(placement_q.size(), pred);
        sent_items++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (placement_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPACING_W-1:0] data);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SPACING)
            spacing_sq = data;
        else
            target_reg = data[TARGET_W-1:0];
    endtask

    task automatic test_before_begin();
        // Registers at reset give a zero target, so the candidate is ignored.
        send_item(candidate(18, -18));
        write_reg(REG_TARGET, SPACING_W'(2));
        send_item(candidate(-5, 7));
    endtask

    task automatic test_zero_target();
        write_reg(REG_TARGET, '0);
        send_item(begin_item());
        send_item(candidate(100, 100));
    endtask

    task automatic test_field_extremes();
        scatter_item_t it;
        write_reg(REG_SPACING, {SPACING_W{1'b1}});
        write_reg(REG_TARGET, SPACING_W'(5));
        send_item(begin_item());
        it = candidate(-(2 ** 23), -(2 ** 23));
        it.yaw = '1;
        it.scale = '1;
        it.model = '1;
        send_item(it);
        it = candidate(2 ** 23 - 1, 2 ** 23 - 1);
        it.yaw = '0;
        it.scale = '0;
        it.model = '0;
        send_item(it);
        send_item(candidate(2 ** 23 - 1, -(2 ** 23)));
    endtask

    task automatic test_spacing_boundary();
        write_reg(REG_SPACING, SPACING_W'(25));
        write_reg(REG_TARGET, SPACING_W'(4));
        send_item(begin_item());
        send_item(candidate(0, 0));
        // Exactly at the spacing counts as far enough.
        send_item(candidate(3, 4));
        send_item(candidate(3, 3));
        write_reg(REG_SPACING, SPACING_W'(1));
        send_item(candidate(3, 3));
        send_item(candidate(3, 3));
    endtask

    task automatic test_spacing_off();
        write_reg(REG_SPACING, '0);
        write_reg(REG_TARGET, SPACING_W'(3));
        send_item(begin_item());
        repeat (3) send_item(candidate(5, 5));
        send_item(candidate(5, 5));
    endtask

    task automatic test_register_change();
        write_reg(REG_TARGET, SPACING_W'(6));
        send_item(begin_item());
        repeat (3) send_item(candidate(int'($urandom), int'($urandom)));
        // Lowering the target below the placed count closes the batch at once.
        write_reg(REG_TARGET, SPACING_W'(2));
        send_item(candidate(1, 1));
        write_reg(REG_TARGET, SPACING_W'(MAX_PTS));
        send_item(candidate(2, 2));
        write_reg(REG_TARGET, {SPACING_W{1'b0}} | {TARGET_W{1'b1}});
        send_item(candidate(3, 3));
    endtask

    task automatic test_attempt_limit();
        write_reg(REG_SPACING, SPACING_W'(64'd1 << 40));
        write_reg(REG_TARGET, SPACING_W'(2));
        send_item(begin_item());
        send_item(candidate(1000, -1000));
        // One placement plus 111 rejections reaches the 112 attempts of a target of two.
        repeat (111)
            send_item(candidate(1000 + $urandom_range(0, 10000) - 5000,
                                -1000 + $urandom_range(0, 10000) - 5000));
        repeat (2) send_item(candidate(int'($urandom), int'($urandom)));
        send_item(begin_item());
    endtask

    task automatic test_random_batches();
        int                   sel;
        int                   halfw;
        int                   n;
        int                   cx;
        int                   cz;
        longint               s;
        logic [TARGET_W-1:0]  tgt;
        logic [SPACING_W-1:0] sq;
        while (sent_items < ITEMS_TOTAL) begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                tgt = TARGET_W'($urandom_range(1, 12));
            else if (sel < 85)
                tgt = TARGET_W'($urandom_range(13, 60));
            else if (sel < 90)
                tgt = '0;
            else if (sel < 95)
                tgt = $urandom_range(0, 1) ? TARGET_W'(MAX_PTS) : '1;
            else
                tgt = TARGET_W'($urandom_range(61, 2047));

            case ($urandom_range(0, 4))
                0:       halfw = 8;
                1:       halfw = 300;
                2:       halfw = 40000;
                3:       halfw = 3000000;
                default: halfw = 2 ** 23;
            endcase

            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                sq = '0;
            end else if (sel < 80) begin
                s = halfw / $urandom_range(1, 6);
                sq = SPACING_W'(s * s);
            end else if (sel < 90) begin
                sq = SPACING_W'({$urandom, $urandom});
            end else if (sel < 95) begin
                sq = '1;
            end else begin
                sq = SPACING_W'(1);
            end

            write_reg(REG_TARGET, SPACING_W'(tgt));
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_SPACING, sq);

            cx = int'($urandom_range(0, 2 ** 24 - 1)) - 2 ** 23;
            cz = int'($urandom_range(0, 2 ** 24 - 1)) - 2 ** 23;
            if ($urandom_range(0, 6) == 0) begin
                cx = $urandom_range(0, 1) ? 2 ** 23 - 1 : -(2 ** 23);
                cz = $urandom_range(0, 1) ? 2 ** 23 - 1 : -(2 ** 23);
            end

            // Most batches open with a begin; the rest carry on from the previous state.
            if ($urandom_range(0, 99) < 85)
                send_item(begin_item());

            if (tgt > 60)
                n = $urandom_range(20, 80);
            else
                n = $urandom_range(1, 2 * tgt + 4);
            if (tgt <= 2 && $urandom_range(0, 9) == 0)
                n = tgt * ATTEMPTS_PER_POINT + ATTEMPTS_EXTRA + 6;

            repeat (n) begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    send_item(begin_item());
                else if (sel < 11)
                    send_item(candidate(int'($urandom), int'($urandom)));
                else
                    send_item(candidate(cx + $urandom_range(0, 2 * halfw) - halfw,
                                        cz + $urandom_range(0, 2 * halfw) - halfw));
            end
        end
    endtask

    // Receiver: the stall behavior changes with the cycle count, among four modes.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            case ((cycle_count / 256) % 4)
                0: m_ready <= 1'b1;
                1: begin
                    if ($urandom_range(0, 3) == 0)
                        ready_hold = $urandom_range(0, 1);
                    m_ready <= (ready_hold == 0) && ($urandom_range(0, 3) != 0);
                end
                2: begin
                    if ($urandom_range(0, 6) == 0)
                        ready_hold = $urandom_range(1, 24);
                    m_ready <= (ready_hold == 0);
                end
                default: m_ready <= cycle_count[0];
            endcase
        end
    end

    task automatic report_mismatch(input string why);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: got st %0d id %0d x %0d z %0d yaw %0d sc %0d mdl %0d fin %0b",
                     $realtime, why, got_r.status, got_r.id, $signed(got_r.x),
                     $signed(got_r.z), got_r.yaw, got_r.scale, got_r.model, got_r.finished);
            $display("    want st %0d id %0d x %0d z %0d yaw %0d sc %0d mdl %0d fin %0b",
                     want_r.status, want_r.id, $signed(want_r.x), $signed(want_r.z),
                     want_r.yaw, want_r.scale, want_r.model, want_r.finished);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_r.status   = m_status;
            got_r.id       = m_instance_id;
            got_r.x        = m_out_x;
            got_r.z        = m_out_z;
            got_r.yaw      = m_out_yaw;
            got_r.scale    = m_out_scale;
            got_r.model    = m_out_model;
            got_r.finished = m_finished;
            if (placement_q.size() == 0) begin
                want_r = '0;
                report_mismatch("result with no transaction outstanding");
            end else begin
                want_r = placement_q.pop_front();
                if (got_r.status !== want_r.status || got_r.id !== want_r.id ||
                    got_r.x !== want_r.x || got_r.z !== want_r.z ||
                    got_r.yaw !== want_r.yaw || got_r.scale !== want_r.scale ||
                    got_r.model !== want_r.model || got_r.finished !== want_r.finished)
                    report_mismatch("result mismatch");
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_min_spacing_point_scatter: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_before_begin();
        test_zero_target();
        test_field_extremes();
        test_spacing_boundary();
        test_spacing_off();
        test_register_change();
        test_attempt_limit();
        test_random_batches();

        wait_drained();
        // A candidate may take a comparison per stored point before a stray result shows.
        repeat (MAX_PTS + 16) @(posedge aclk);
        if (mismatches == 0 && placement_q.size() == 0)
            $display("tb_min_spacing_point_scatter: PASS");
        else
            $display("tb_min_spacing_point_scatter: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/msps_pkg.sv
hw/rtl/msps_store.sv
hw/rtl/msps_dist.sv
hw/rtl/min_spacing_point_scatter.sv
sim/tb_min_spacing_point_scatter.sv
